/* src/edf_pkg.sv */
package edf_pkg;

	localparam int NTASK = 3;
	localparam int REM_STEPS = 16;

	typedef enum logic [2:0] {
		REG_PERIOD_A = 3'd0,
		REG_PERIOD_B = 3'd1,
		REG_PERIOD_C = 3'd2,
		REG_BUDGET_A = 3'd3,
		REG_BUDGET_B = 3'd4,
		REG_BUDGET_C = 3'd5,
		REG_QUANTUM  = 3'd6
	} cfg_reg_t;

	localparam logic [15:0] PERIOD_A_RST = 16'd30;
	localparam logic [15:0] PERIOD_B_RST = 16'd40;
	localparam logic [15:0] PERIOD_C_RST = 16'd50;
	localparam logic [15:0] BUDGET_A_RST = 16'd10;
	localparam logic [15:0] BUDGET_B_RST = 16'd15;
	localparam logic [15:0] BUDGET_C_RST = 16'd5;
	localparam logic [7:0]  QUANTUM_RST  = 8'd5;

	typedef struct packed {
		logic [15:0] phase;
		logic [15:0] remaining;
	} task_t;

	typedef struct packed {
		logic [15:0] time_now;
		logic [1:0]  chosen_task;
		logic [2:0]  released_mask;
		logic [2:0]  pending_mask;
	} result_t;

	// one restoring remainder step: shift in a dividend bit, subtract if it fits
	function automatic logic [15:0] rem_step(input logic [15:0] r, input logic b,
	                                         input logic [15:0] d);
		logic [16:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) t = t - {1'b0, d};
		return t[15:0];
	endfunction

endpackage

/* src/edf_rem.sv */
module edf_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] period,
	input  logic [15:0] phase,
	input  logic [7:0]  quantum,
	output logic [15:0] phase_mod,
	output logic [15:0] quantum_mod,
	output logic        busy
);

	logic [4:0]  cnt_q;
	logic [3:0]  bit_idx;
	logic [15:0] prem_q;
	logic [15:0] qrem_q;
	logic [15:0] q_ext;

	assign bit_idx = 4'(cnt_q - 5'd1);
	assign q_ext = {8'd0, quantum};
	assign busy = (cnt_q != 5'd0);
	assign phase_mod = prem_q;
	assign quantum_mod = qrem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'(edf_pkg::REM_STEPS);
		end else if (cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// dividend bits are taken from the live registers, msb first
	always_ff @(posedge clk) begin
		if (start) begin
			prem_q <= 16'd0;
			qrem_q <= 16'd0;
		end else if (cnt_q != 5'd0) begin
			prem_q <= edf_pkg::rem_step(prem_q, phase[bit_idx], period);
			qrem_q <= edf_pkg::rem_step(qrem_q, q_ext[bit_idx], period);
		end
	end

endmodule

/* src/edf_tick.sv */
module edf_tick #(
	parameter int TIME_BITS = 16
) (
	input  logic                                      restart,
	input  logic [TIME_BITS-1:0]                      time_cur,
	input  edf_pkg::task_t [edf_pkg::NTASK-1:0]       tasks,
	input  logic [edf_pkg::NTASK-1:0][15:0]           period,
	input  logic [edf_pkg::NTASK-1:0][15:0]           budget,
	input  logic [7:0]                                quantum,
	input  logic [edf_pkg::NTASK-1:0][15:0]           phase_mod,
	input  logic [edf_pkg::NTASK-1:0][15:0]           quantum_mod,
	output logic [TIME_BITS-1:0]                      time_nxt,
	output edf_pkg::task_t [edf_pkg::NTASK-1:0]       tasks_nxt,
	output edf_pkg::result_t                          result
);

	logic [TIME_BITS-1:0]     t_cur;
	logic [TIME_BITS+15:0]    t_wide;

	assign t_cur = restart ? '0 : time_cur;
	assign t_wide = {16'd0, t_cur};
	assign time_nxt = t_cur + TIME_BITS'(quantum);

	always_comb begin
		logic [15:0] ph     [edf_pkg::NTASK];
		logic [15:0] rm     [edf_pkg::NTASK];
		logic [15:0] dl     [edf_pkg::NTASK];
		logic [15:0] base;
		logic [16:0] sum;
		logic [15:0] best_dl;
		logic        have;
		logic [1:0]  chosen;
		logic [2:0]  released;
		logic [2:0]  pending;

		have = 1'b0;
		best_dl = 16'd0;
		chosen = 2'd0;
		released = 3'd0;
		pending = 3'd0;

		for (int i = 0; i < edf_pkg::NTASK; i++) begin
			ph[i] = restart ? 16'd0 : tasks[i].phase;
			rm[i] = restart ? 16'd0 : tasks[i].remaining;
			if (ph[i] == 16'd0) begin
				rm[i] = budget[i];
				released[i] = 1'b1;
			end
			dl[i] = (ph[i] < period[i]) ? (period[i] - ph[i]) : 16'd0;
		end

		// earliest deadline wins, lower index on a tie
		for (int i = 0; i < edf_pkg::NTASK; i++) begin
			if (rm[i] != 16'd0 && (!have || dl[i] < best_dl)) begin
				have = 1'b1;
				best_dl = dl[i];
				chosen = 2'(i + 1);
			end
		end

		for (int i = 0; i < edf_pkg::NTASK; i++) begin
			if (chosen == 2'(i + 1))
				rm[i] = (rm[i] > {8'd0, quantum}) ? (rm[i] - {8'd0, quantum}) : 16'd0;
			pending[i] = (rm[i] != 16'd0);
			tasks_nxt[i].remaining = rm[i];

			// both addends are below the period, so one subtract wraps it
			base = (ph[i] < period[i]) ? ph[i] : phase_mod[i];
			sum = {1'b0, base} + {1'b0, quantum_mod[i]};
			if (sum >= {1'b0, period[i]}) sum = sum - {1'b0, period[i]};
			tasks_nxt[i].phase = (period[i] == 16'd0) ? 16'd0 : sum[15:0];
		end

		result.time_now = t_wide[15:0];
		result.chosen_task = chosen;
		result.released_mask = released;
		result.pending_mask = pending;
	end

endmodule

/* src/edf_task_scheduler.sv */
// EDF scheduler for three periodic tasks. Every input beat is one tick of
// "quantum" time units; the block releases jobs for tasks whose phase is zero,
// grants the ready task with the earliest deadline (lower task on a tie), and
// returns one result beat per tick. Ticks are taken one per clock cycle while
// neither the remainder units nor a stalled output hold them: a beat sits in
// the input register and is scheduled on its way into the output register.
// Phases advance modulo each period using per-task remainders of quantum
// (and of a stale phase) that three bit-serial remainder units compute after
// reset and after every configuration write; input stays stalled while they
// run.
module edf_task_scheduler #(
	parameter int TIME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] time_now,
	output logic [1:0]  chosen_task,
	output logic [2:0]  released_mask,
	output logic [2:0]  pending_mask
);

	localparam int NT = edf_pkg::NTASK;

	logic [NT-1:0][15:0]         period_q;
	logic [NT-1:0][15:0]         budget_q;
	logic [7:0]                  quantum_q;
	logic [TIME_BITS-1:0]        time_q;
	edf_pkg::task_t [NT-1:0]     task_q;
	logic                        init_q;

	logic                        valid_s1;
	logic                        restart_s1;
	logic                        valid_s2;
	edf_pkg::result_t            res_s2;

	logic [NT-1:0][15:0]         phase_mod;
	logic [NT-1:0][15:0]         quantum_mod;
	logic [NT-1:0]               rem_busy;
	logic                        start;
	logic                        busy;
	logic                        advance;
	logic                        in_accept;

	logic [TIME_BITS-1:0]        time_nxt;
	edf_pkg::task_t [NT-1:0]     task_nxt;
	edf_pkg::result_t            res_nxt;

	assign start = cfg_we | init_q;
	assign busy = start | (|rem_busy);
	assign advance = valid_s1 & ~busy & (~valid_s2 | ~out_stall);
	assign in_stall = busy | (valid_s1 & ~advance);
	assign in_accept = in_valid & ~in_stall;

	genvar g;
	generate
		for (g = 0; g < NT; g++) begin : g_rem
			edf_rem u_rem (
				.clk         (clk),
				.arst_n      (arst_n),
				.start       (start),
				.period      (period_q[g]),
				.phase       (task_q[g].phase),
				.quantum     (quantum_q),
				.phase_mod   (phase_mod[g]),
				.quantum_mod (quantum_mod[g]),
				.busy        (rem_busy[g])
			);
		end
	endgenerate

	edf_tick #(.TIME_BITS(TIME_BITS)) u_tick (
		.restart     (restart_s1),
		.time_cur    (time_q),
		.tasks       (task_q),
		.period      (period_q),
		.budget      (budget_q),
		.quantum     (quantum_q),
		.phase_mod   (phase_mod),
		.quantum_mod (quantum_mod),
		.time_nxt    (time_nxt),
		.tasks_nxt   (task_nxt),
		.result      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= {edf_pkg::PERIOD_C_RST, edf_pkg::PERIOD_B_RST, edf_pkg::PERIOD_A_RST};
			budget_q <= {edf_pkg::BUDGET_C_RST, edf_pkg::BUDGET_B_RST, edf_pkg::BUDGET_A_RST};
			quantum_q <= edf_pkg::QUANTUM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				edf_pkg::REG_PERIOD_A: period_q[0] <= cfg_data;
				edf_pkg::REG_PERIOD_B: period_q[1] <= cfg_data;
				edf_pkg::REG_PERIOD_C: period_q[2] <= cfg_data;
				edf_pkg::REG_BUDGET_A: budget_q[0] <= cfg_data;
				edf_pkg::REG_BUDGET_B: budget_q[1] <= cfg_data;
				edf_pkg::REG_BUDGET_C: budget_q[2] <= cfg_data;
				edf_pkg::REG_QUANTUM:  quantum_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b1;
			time_q <= '0;
			task_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			init_q <= 1'b0;
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				time_q <= time_nxt;
				task_q <= task_nxt;
				valid_s2 <= 1'b1;
			end else if (~out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) restart_s1 <= restart;
		if (advance) res_s2 <= res_nxt;
	end

	assign out_valid = valid_s2;
	assign time_now = res_s2.time_now;
	assign chosen_task = res_s2.chosen_task;
	assign released_mask = res_s2.released_mask;
	assign pending_mask = res_s2.pending_mask;

endmodule

/* src/edf_checker.sv */
module edf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] time_now,
	input logic [1:0]  chosen_task,
	input logic [2:0]  pending_mask
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(time_now) && $stable(chosen_task))
		else $error("result beat changed while stalled");

	// an idle tick means no job had budget left
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chosen_task == 2'd0 |-> pending_mask == 3'd0)
		else $error("idle tick with pending work");

	// remainders are recomputed after a write, so input holds off
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken right after a configuration write");

endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.time_now     (time_now),
	.chosen_task  (chosen_task),
	.pending_mask (pending_mask)
);

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int HOLD_CYCLES = 80;
	localparam int TICK_TARGET = 1350;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = edf_pkg::REG_PERIOD_A;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] time_now;
	logic [1:0]  chosen_task;
	logic [2:0]  released_mask;
	logic [2:0]  pending_mask;

	edf_task_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.time_now(time_now),
		.chosen_task(chosen_task),
		.released_mask(released_mask),
		.pending_mask(pending_mask)
	);

	always #6 clk = ~clk;

	// scheduler copy: registers and per-task state
	logic [15:0] cfg_period [edf_pkg::NTASK];
	logic [15:0] cfg_budget [edf_pkg::NTASK];
	logic [7:0]  cfg_quantum;
	logic [15:0] clock_now;
	logic [15:0] task_phase [edf_pkg::NTASK];
	logic [15:0] task_left [edf_pkg::NTASK];

	bit               restart_plan [$];
	edf_pkg::result_t owed_ticks [$];
	int      ticks_planned = 0;
	int      ticks_sent = 0;
	int      ticks_seen = 0;
	int      restarts_sent = 0;
	int      reg_writes = 0;
	int      settings_run = 0;
	int      grant_count [4] = '{0, 0, 0, 0};
	int      faults = 0;
	bit      steady = 1'b0;
	int      send_wait = 0;
	int      recv_wait = 0;
	int      hold_at = -1;
	int      hold_fired_at = -1;
	int      hold_left = 0;

	function automatic edf_pkg::result_t edf_tick(logic clear);
		edf_pkg::result_t r;
		logic [2:0]  rel, pend;
		logic [1:0]  pick;
		logic [15:0] dl, best;
		logic [16:0] adv;
		rel = '0;
		pend = '0;
		pick = 2'd0;
		best = '0;
		if (clear) begin
			clock_now = '0;
			for (int i = 0; i < edf_pkg::NTASK; i++) begin
				task_phase[i] = '0;
				task_left[i] = '0;
			end
		end
		for (int i = 0; i < edf_pkg::NTASK; i++)
			if (task_phase[i] == 16'd0) begin
				task_left[i] = cfg_budget[i];
				rel[i] = 1'b1;
			end
		// earliest deadline wins, strict compare keeps the lower task on a tie
		for (int i = 0; i < edf_pkg::NTASK; i++)
			if (task_left[i] != 16'd0) begin
				dl = (task_phase[i] < cfg_period[i]) ? cfg_period[i] - task_phase[i] : 16'd0;
				if (pick == 2'd0 || dl < best) begin
					best = dl;
					pick = 2'(i + 1);
				end
			end
		if (pick != 2'd0)
			task_left[pick - 1] = (task_left[pick - 1] > {8'd0, cfg_quantum}) ?
				task_left[pick - 1] - {8'd0, cfg_quantum} : 16'd0;
		for (int i = 0; i < edf_pkg::NTASK; i++)
			pend[i] = (task_left[i] != 16'd0);
		r.time_now = clock_now;
		r.chosen_task = pick;
		r.released_mask = rel;
		r.pending_mask = pend;
		clock_now = clock_now + {8'd0, cfg_quantum};
		for (int i = 0; i < edf_pkg::NTASK; i++) begin
			adv = {1'b0, task_phase[i]} + {9'd0, cfg_quantum};
			task_phase[i] = (cfg_period[i] == 16'd0) ? 16'd0 : 16'(adv % {1'b0, cfg_period[i]});
		end
		return r;
	endfunction

	task automatic flag_fault(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		faults++;
	endtask

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// sender: one beat per planned tick, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			send_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				owed_ticks.push_back(edf_tick(restart));
				ticks_sent <= ticks_sent + 1;
				if (restart)
					restarts_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					in_valid <= 1'b0;
				end else if (restart_plan.size() != 0) begin
					in_valid <= 1'b1;
					restart <= restart_plan.pop_front();
					send_wait <= draw_wait();
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, armed by the sequence at a chosen tick count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (ticks_sent == hold_at && hold_fired_at != hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_fired_at <= hold_at;
		end
	end

	// receiver: check each result beat against the oldest owed tick
	always @(posedge clk or negedge arst_n) begin
		edf_pkg::result_t want;
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				ticks_seen++;
				grant_count[chosen_task]++;
				if (owed_ticks.size() == 0)
					flag_fault("result beat with no tick owed");
				else begin
					want = owed_ticks.pop_front();
					if (time_now !== want.time_now)
						flag_fault($sformatf("tick %0d time_now %0d, want %0d",
							ticks_seen, time_now, want.time_now));
					if (chosen_task !== want.chosen_task)
						flag_fault($sformatf("tick %0d chosen_task %0d, want %0d",
							ticks_seen, chosen_task, want.chosen_task));
					if (released_mask !== want.released_mask)
						flag_fault($sformatf("tick %0d released_mask %b, want %b",
							ticks_seen, released_mask, want.released_mask));
					if (pending_mask !== want.pending_mask)
						flag_fault($sformatf("tick %0d pending_mask %b, want %b",
							ticks_seen, pending_mask, want.pending_mask));
				end
				recv_wait = draw_wait();
			end else if (recv_wait != 0)
				recv_wait--;
			out_stall <= (recv_wait != 0) || (hold_left != 0);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		reg_writes++;
		case (idx)
			edf_pkg::REG_PERIOD_A: cfg_period[0] = data;
			edf_pkg::REG_PERIOD_B: cfg_period[1] = data;
			edf_pkg::REG_PERIOD_C: cfg_period[2] = data;
			edf_pkg::REG_BUDGET_A: cfg_budget[0] = data;
			edf_pkg::REG_BUDGET_B: cfg_budget[1] = data;
			edf_pkg::REG_BUDGET_C: cfg_budget[2] = data;
			edf_pkg::REG_QUANTUM:  cfg_quantum = data[7:0];
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (ticks_sent != ticks_planned || owed_ticks.size() != 0);
	endtask

	task automatic plan(bit r);
		restart_plan.push_back(r);
		ticks_planned++;
	endtask

	function automatic logic [15:0] draw_setting(logic [2:0] idx);
		int pick;
		logic [7:0] noise;
		pick = $urandom_range(0, 9);
		noise = 8'($urandom);
		if (idx == edf_pkg::REG_QUANTUM)
			case (pick)
				0: return {noise, 8'd0};
				1: return {noise, 8'hFF};
				2: return {noise, 8'($urandom_range(1, 255))};
				default: return {noise, 8'($urandom_range(1, 12))};
			endcase
		case (pick)
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return (idx <= edf_pkg::REG_PERIOD_C) ? 16'($urandom_range(1, 60)) :
				16'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic run_random_phase(int n, bit burst);
		wait_idle();
		for (int i = edf_pkg::REG_PERIOD_A; i <= edf_pkg::REG_QUANTUM; i++)
			if ($urandom_range(0, 1) == 1)
				write_reg(3'(i), draw_setting(3'(i)));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, 16'($urandom));
		finish_writes();
		steady = burst || ($urandom_range(0, 4) == 0);
		if (burst)
			hold_at = ticks_planned + 30;
		plan($urandom_range(0, 3) == 0);
		repeat (n - 1)
			plan($urandom_range(0, 39) == 0);
	endtask

	initial begin
		cfg_period = '{edf_pkg::PERIOD_A_RST, edf_pkg::PERIOD_B_RST, edf_pkg::PERIOD_C_RST};
		cfg_budget = '{edf_pkg::BUDGET_A_RST, edf_pkg::BUDGET_B_RST, edf_pkg::BUDGET_C_RST};
		cfg_quantum = edf_pkg::QUANTUM_RST;
		clock_now = '0;
		task_phase = '{16'd0, 16'd0, 16'd0};
		task_left = '{16'd0, 16'd0, 16'd0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, restart at the start and mid-way
		plan(1'b1);
		repeat (4) plan(1'b0);
		plan(1'b1);
		repeat (2) plan(1'b0);

		// zero period on task one, zero budget on task three, quantum above its period
		wait_idle();
		write_reg(edf_pkg::REG_PERIOD_A, 16'd0);
		write_reg(edf_pkg::REG_PERIOD_B, 16'hFFFF);
		write_reg(edf_pkg::REG_PERIOD_C, 16'd3);
		write_reg(edf_pkg::REG_BUDGET_A, 16'hFFFF);
		write_reg(edf_pkg::REG_BUDGET_B, 16'd40000);
		write_reg(edf_pkg::REG_BUDGET_C, 16'd0);
		write_reg(edf_pkg::REG_QUANTUM, 16'hA5FF);
		write_reg(REG_SPARE, 16'h5A5A);
		finish_writes();
		repeat (6) plan(1'b0);

		// lower period below the phase of task two, zero quantum
		wait_idle();
		write_reg(edf_pkg::REG_PERIOD_B, 16'd2);
		write_reg(edf_pkg::REG_BUDGET_A, 16'd0);
		write_reg(edf_pkg::REG_QUANTUM, 16'h5A00);
		finish_writes();
		repeat (4) plan(1'b0);

		// unit quantum and period, large budget
		wait_idle();
		write_reg(edf_pkg::REG_QUANTUM, 16'h0001);
		write_reg(edf_pkg::REG_PERIOD_A, 16'd1);
		write_reg(edf_pkg::REG_BUDGET_A, 16'd3);
		write_reg(edf_pkg::REG_BUDGET_C, 16'hFFFF);
		finish_writes();
		plan(1'b1);
		repeat (4) plan(1'b0);

		run_random_phase(150, 1'b1);
		for (int p = 0; ticks_planned < TICK_TARGET; p++)
			run_random_phase($urandom_range(60, 140), p == 4);

		wait_idle();
		repeat (8) @(posedge clk);
		if (owed_ticks.size() != 0)
			flag_fault($sformatf("%0d ticks still owed at the end", owed_ticks.size()));
		$display("%0d ticks checked over %0d register settings, %0d writes, %0d restarts",
			ticks_seen, settings_run, reg_writes, restarts_sent);
		$display("grants: idle %0d, task one %0d, task two %0d, task three %0d; %0d mismatches",
			grant_count[0], grant_count[1], grant_count[2], grant_count[3], faults);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d ticks sent, %0d results seen", ticks_sent, ticks_seen);
		$display("testbench NOT OK");
		$finish;
	end

endmodule

/* edf_task_scheduler.f */
src/edf_pkg.sv
src/edf_rem.sv
src/edf_tick.sv
src/edf_task_scheduler.sv
src/edf_checker.sv
bench/testbench.sv
